@@ hw/rtl/sis_pkg.sv @@
`default_nettype none

package sis_pkg;

   // Operation carried by each request.
   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_TEST   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_WR,
      ST_KEY_WR,
      ST_DN_RD,
      ST_DN_WR,
      ST_RESP
   } state_type;

   localparam int unsigned POS_W   = 9;
   localparam int unsigned RSP_W   = 24;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // take the request, start a new search window
      logic clear;     // empty the set
      logic probe;     // read the middle entry of the window
      logic compare;   // narrow the window with the probed entry
      logic finish;    // window empty: position is the insertion point
      logic set_full;  // add dropped
      logic init_up;   // shift pointer to the end of the list
      logic rd_up;     // read the entry below the shift pointer
      logic wr_up;     // move it up one place
      logic wr_key;    // insert the key and grow the count
      logic init_dn;   // shift pointer to the found position
      logic rd_dn;     // read the entry above the shift pointer
      logic wr_dn;     // move it down one place
      logic shrink;    // drop the last entry from the count
      logic emit;      // load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     lo_lt_hi;
      logic     key_eq;
      logic     found;
      logic     full;
      logic     idx_eq_pos;
      logic     idx_last;
      logic     rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/sis_ram.sv @@
`default_nettype none

module sis_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/sis_ctrl.sv @@
`default_nettype none

module sis_ctrl
   import sis_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.mode == MODE_CLEAR) begin
               state_in = ST_RESP;
            end else if (stat.lo_lt_hi) begin
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_COMPARE: begin
            state_in = stat.key_eq ? ST_DECIDE : ST_SEARCH;
         end
         ST_DECIDE: begin
            if (stat.mode == MODE_ADD && !stat.found) begin
               state_in = stat.full ? ST_RESP : ST_UP_RD;
            end else if (stat.mode == MODE_REMOVE && stat.found) begin
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UP_RD:  state_in = stat.idx_eq_pos ? ST_KEY_WR : ST_UP_WR;
         ST_UP_WR:  state_in = ST_UP_RD;
         ST_KEY_WR: state_in = ST_RESP;
         ST_DN_RD:  state_in = stat.idx_last ? ST_RESP : ST_DN_WR;
         ST_DN_WR:  state_in = ST_DN_RD;
         ST_RESP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SEARCH: begin
            if (stat.mode == MODE_CLEAR) begin
               cmd.clear = 1'b1;
            end else if (stat.lo_lt_hi) begin
               cmd.probe = 1'b1;
            end else begin
               cmd.finish = 1'b1;
            end
         end
         ST_COMPARE: cmd.compare = 1'b1;
         ST_DECIDE: begin
            if (stat.mode == MODE_ADD && !stat.found) begin
               cmd.set_full = stat.full;
               cmd.init_up  = !stat.full;
            end else if (stat.mode == MODE_REMOVE && stat.found) begin
               cmd.init_dn = 1'b1;
            end
         end
         ST_UP_RD:  cmd.rd_up  = !stat.idx_eq_pos;
         ST_UP_WR:  cmd.wr_up  = 1'b1;
         ST_KEY_WR: cmd.wr_key = 1'b1;
         ST_DN_RD: begin
            cmd.shrink = stat.idx_last;
            cmd.rd_dn  = !stat.idx_last;
         end
         ST_DN_WR:  cmd.wr_dn = 1'b1;
         ST_RESP:   cmd.emit  = stat.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/sis_dp.sv @@
`default_nettype none

module sis_dp
   import sis_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output stat_type           stat,
   input  wire logic [1:0]    req_mode,
   input  wire logic [31:0]   req_ident,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   mode_type          mode_ff, mode_in;
   logic [31:0]       key_ff, key_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              found_ff, found_in;
   logic              full_ff, full_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [CW:0]       win_sum;
   logic [AW-1:0]     mid_calc;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [31:0]       ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [31:0]       ram_rdata;

   assign win_sum  = (CW + 1)'(lo_ff) + (CW + 1)'(hi_ff);
   assign mid_calc = AW'(win_sum >> 1);

   sis_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Memory port selection.
   always_comb begin
      ram_re    = cmd.probe | cmd.rd_up | cmd.rd_dn;
      ram_raddr = mid_calc;
      if (cmd.rd_up) begin
         ram_raddr = AW'(idx_ff - CW'(1));
      end else if (cmd.rd_dn) begin
         ram_raddr = AW'(idx_ff + CW'(1));
      end
      ram_we    = cmd.wr_up | cmd.wr_dn | cmd.wr_key;
      ram_waddr = cmd.wr_key ? AW'(pos_ff) : AW'(idx_ff);
      ram_wdata = cmd.wr_key ? key_ff : ram_rdata;
   end

   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         mode_in  = mode_type'(req_mode);
         key_in   = req_ident;
         lo_in    = '0;
         hi_in    = count_ff;
         pos_in   = '0;
         found_in = 1'b0;
         full_in  = 1'b0;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.probe) begin
         mid_in = mid_calc;
      end
      if (cmd.compare) begin
         if (key_ff == ram_rdata) begin
            pos_in   = CW'(mid_ff);
            found_in = 1'b1;
         end else if (key_ff > ram_rdata) begin
            lo_in = CW'(mid_ff) + CW'(1);
         end else begin
            hi_in = CW'(mid_ff);
         end
      end
      if (cmd.finish) begin
         pos_in = lo_ff;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.init_up) begin
         idx_in = count_ff;
      end
      if (cmd.wr_up) begin
         idx_in = idx_ff - CW'(1);
      end
      if (cmd.wr_key) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.init_dn) begin
         idx_in = pos_ff;
      end
      if (cmd.wr_dn) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.shrink) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, full_ff, POS_W'(count_ff), POS_W'(pos_ff), found_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.mode       = mode_ff;
      stat.lo_lt_hi   = lo_ff < hi_ff;
      stat.key_eq     = key_ff == ram_rdata;
      stat.found      = found_ff;
      stat.full       = count_ff == CAP_COUNT;
      stat.idx_eq_pos = idx_ff == pos_ff;
      stat.idx_last   = (idx_ff + CW'(1)) == count_ff;
      stat.rsp_free   = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_id_set.sv @@
// Sorted identifier set. The block keeps up to CAPACITY distinct 32-bit
// identifiers as an ascending list in a single simple dual-port RAM. Each
// request clears the set, adds an identifier, removes one or tests for one,
// and every request yields exactly one response. The position is found by a
// binary search in which each probe is one RAM read followed by one compare.
// An add then moves every entry above the insertion point up by one place
// and a remove moves them down, one entry at a time through the single RAM
// port pair, so a clear is the shortest request and an add or remove near
// the bottom of a nearly full list the longest. The block takes one request
// at a time; a finished response waits in an output register while the next
// request is accepted. An add to a full set is dropped and reported with the
// status bit. There is no clearing pass after reset: entries above the count
// are never read.
`default_nettype none

module sorted_id_set
   import sis_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] ident
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [0] was_present, [9:1] position,
                                         // [18:10] entry_count, [19] status,
                                         // [23:20] zero
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences search, shift and response; the datapath holds
   // the search window, the shift pointer, the count and the list RAM.
   sis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sis_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_mode   (req_tuser),
      .req_ident  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ hw/rtl/sis_checker.sv @@
`default_nettype none

module sis_checker #(
   parameter int unsigned CAPACITY = 256
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   localparam logic [8:0] CAP_COUNT = 9'(CAPACITY);

   // A held response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One request at a time: the block is busy right after taking one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   // A dropped add only happens on a full set and for an absent id.
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> rsp_tdata[18:10] == CAP_COUNT && !rsp_tdata[0])
      else $error("dropped add without a full set");

   // For CAPACITY up to 256, the reported position never lies beyond the list.
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 256) || (rsp_tdata[9:1] <= rsp_tdata[18:10]))
      else $error("position beyond entry count");

   // The mode of a taken request is always a known value.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tuser))
      else $error("request mode unknown");

endmodule

bind sorted_id_set sis_checker #(
   .CAPACITY (CAPACITY)
) u_sis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
